FILE: hw/rtl/tiba_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tiba_pkg
// Shared widths, register codes and types of the temporal IIR bandpass
// amplifier: per-channel lanes, averages memory and output queue.
// ----------------------------------------------------------------------------
package tiba_pkg;

    localparam int PIXEL_COUNT = 2048;
    localparam int ADDR_W      = $clog2(PIXEL_COUNT);

    localparam int LANES    = 3;
    localparam int LEVEL_W  = 16;
    localparam int AVG_W    = 24;
    localparam int FRAC_PAD = AVG_W - LEVEL_W;
    localparam int COEF_W   = 16;
    localparam int GAIN_W   = 10;
    localparam int BOOST_W  = 24;
    localparam int INDEX_W  = 11;

    localparam int S_FIELDS_W = LANES * LEVEL_W + INDEX_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_FIELDS_W = LANES * BOOST_W + INDEX_W;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [COEF_W-1:0] FAST_COEF_RESET = COEF_W'(6554);
    localparam logic [COEF_W-1:0] SLOW_COEF_RESET = COEF_W'(5461);
    localparam logic [GAIN_W-1:0] GAIN_RESET      = GAIN_W'(200);

    localparam int OUTQ_DEPTH = 8;
    localparam int OUTQ_PTR_W = $clog2(OUTQ_DEPTH);
    localparam int OUTQ_CNT_W = $clog2(OUTQ_DEPTH + 1);

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_FAST_COEF = 2'd0,
        CFG_SLOW_COEF = 2'd1,
        CFG_GAIN      = 2'd2
    } cfg_index_t;

    typedef logic [LEVEL_W-1:0]        level_t;
    typedef logic [AVG_W-1:0]          avg_t;
    typedef logic signed [BOOST_W-1:0] boost_t;
    typedef logic [INDEX_W-1:0]        index_t;

    typedef logic [LANES-1:0][LEVEL_W-1:0] level_vec_t;
    typedef logic [LANES-1:0][AVG_W-1:0]   avg_vec_t;
    typedef logic [LANES-1:0][BOOST_W-1:0] boost_vec_t;

    typedef struct packed {
        logic [COEF_W-1:0] fast_coef;
        logic [COEF_W-1:0] slow_coef;
        logic [GAIN_W-1:0] gain;
    } lane_cfg_t;

    typedef struct packed {
        logic   valid;
        logic   first;
        index_t index;
        logic   last;
    } meta_t;

    typedef struct packed {
        logic       last;
        index_t     index;
        boost_vec_t boost;
    } outq_entry_t;

endpackage

FILE: hw/rtl/tiba_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tiba_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module tiba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hw/rtl/tiba_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tiba_lane
// One color channel: fast and slow average update with forwarding of the
// previous pixel's result, difference times gain, rounding and saturation.
// ----------------------------------------------------------------------------
module tiba_lane (
    input  logic                aclk,
    input  tiba_pkg::lane_cfg_t cfg,
    input  tiba_pkg::level_t    level,
    input  logic                first,
    input  logic                fwd_hit,
    input  tiba_pkg::avg_t      fast_rd,
    input  tiba_pkg::avg_t      slow_rd,
    output tiba_pkg::avg_t      fast_new,
    output tiba_pkg::avg_t      slow_new,
    output tiba_pkg::boost_t    boost
);
    import tiba_pkg::*;

    localparam int DIFF_W  = AVG_W + 1;
    localparam int BLEND_W = DIFF_W + COEF_W + 1;
    localparam int PROD_W  = DIFF_W + GAIN_W + 1;
    localparam int RND_SH  = AVG_W - LEVEL_W;

    localparam logic signed [BLEND_W-1:0] BLEND_HALF = BLEND_W'(1) <<< (COEF_W - 1);
    localparam logic signed [PROD_W-1:0]  PROD_HALF  = PROD_W'(1) <<< (RND_SH - 1);
    localparam logic signed [PROD_W-1:0]  SAT_HI     = (PROD_W'(1) <<< (BOOST_W - 1)) - PROD_W'(1);
    localparam logic signed [PROD_W-1:0]  SAT_LO     = -(PROD_W'(1) <<< (BOOST_W - 1));

    function automatic avg_t blend(avg_t avg, avg_t x, logic [COEF_W-1:0] c);
        logic signed [DIFF_W-1:0]  diff;
        logic signed [BLEND_W-1:0] prod;
        logic signed [BLEND_W-1:0] step;
        diff = $signed({1'b0, x}) - $signed({1'b0, avg});
        prod = diff * $signed({1'b0, c});
        step = (prod + BLEND_HALF) >>> COEF_W;
        return avg + step[AVG_W-1:0];
    endfunction

    avg_t                     fast_new_reg;
    avg_t                     slow_new_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [DIFF_W-1:0] band;
    logic signed [PROD_W-1:0] rounded;
    avg_t                     x;
    avg_t                     fast_src;
    avg_t                     slow_src;

    assign x        = {level, {FRAC_PAD{1'b0}}};
    assign fast_src = fwd_hit ? fast_new_reg : fast_rd;
    assign slow_src = fwd_hit ? slow_new_reg : slow_rd;

    always_comb begin
        if (first) begin
            fast_new = x;
            slow_new = x;
        end else begin
            fast_new = blend(fast_src, x, cfg.fast_coef);
            slow_new = blend(slow_src, x, cfg.slow_coef);
        end
    end

    always_comb begin
        band      = $signed({1'b0, fast_new_reg}) - $signed({1'b0, slow_new_reg});
        prod_next = band * $signed({1'b0, cfg.gain});
    end

    always_ff @(posedge aclk) begin
        fast_new_reg <= fast_new;
        slow_new_reg <= slow_new;
        prod_reg     <= prod_next;
    end

    always_comb begin
        rounded = (prod_reg + PROD_HALF) >>> RND_SH;
        if (rounded > SAT_HI) begin
            boost = SAT_HI[BOOST_W-1:0];
        end else if (rounded < SAT_LO) begin
            boost = SAT_LO[BOOST_W-1:0];
        end else begin
            boost = rounded[BOOST_W-1:0];
        end
    end

endmodule

FILE: hw/rtl/tiba_outq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tiba_outq
// Merge stage: joins the lane results with the pixel position and frame
// mark, zeroes first-frame results and queues them for the master side.
// ----------------------------------------------------------------------------
module tiba_outq (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  tiba_pkg::meta_t                    meta,
    input  tiba_pkg::boost_vec_t               boost,
    input  logic                               m_tready,
    output logic                               m_tvalid,
    output logic [tiba_pkg::M_TDATA_W-1:0]     m_tdata,  // red, green, blue boost, position
    output logic                               m_tlast
);
    import tiba_pkg::*;

    localparam int PAD_W = M_TDATA_W - M_FIELDS_W;

    outq_entry_t             queue_reg [OUTQ_DEPTH];
    outq_entry_t             entry;
    outq_entry_t             head;
    logic [OUTQ_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [OUTQ_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [OUTQ_CNT_W-1:0]   count_reg, count_next;
    logic                    push;
    logic                    pop;

    assign push = meta.valid;
    assign pop  = m_tvalid & m_tready;

    always_comb begin
        entry.last  = meta.last;
        entry.index = meta.index;
        entry.boost = meta.first ? '0 : boost;
    end

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + OUTQ_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + OUTQ_PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + OUTQ_CNT_W'(push) - OUTQ_CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            queue_reg[wr_ptr_reg] <= entry;
        end
    end

    assign head     = queue_reg[rd_ptr_reg];
    assign m_tvalid = (count_reg != '0);
    assign m_tdata  = {{PAD_W{1'b0}}, head.index, head.boost};
    assign m_tlast  = head.last;

endmodule

FILE: hw/rtl/temporal_iir_bandpass_amplifier.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// temporal_iir_bandpass_amplifier
// Per-pixel temporal bandpass (fast minus slow exponential average) with gain.
// ----------------------------------------------------------------------------
// Takes one pixel per clock while s_tready is high and returns one result
// per pixel, in order. A result passes the s1, s2 and s3 registers before
// it is queued for the master side; three lanes, one per color, each
// update their pixel's averages in a read-modify-write loop around the
// averages memories, and the result of the pixel just before is forwarded,
// so repeated indices keep full rate. Up to eight results may be in flight
// or queued; s_tready drops while eight are, so a stalled master side holds
// off input after eight pixels. The averages memories need no clearing: the
// first frame after reset loads every entry it uses and yields zero boosts.
// Write the coefficient and gain registers only while no pixel is in flight.
// ----------------------------------------------------------------------------
module temporal_iir_bandpass_amplifier (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [tiba_pkg::S_TDATA_W-1:0]      s_tdata,  // red, green, blue level, index
    input  logic                                s_tlast,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [tiba_pkg::M_TDATA_W-1:0]      m_tdata,  // red, green, blue boost, position
    output logic                                m_tlast,
    input  logic                                cfg_wr_en,
    input  logic [tiba_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [tiba_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
    import tiba_pkg::*;

    lane_cfg_t             cfg_reg, cfg_next;
    meta_t                 s1_meta_reg, s1_meta_next;
    meta_t                 s2_meta_reg, s2_meta_next;
    meta_t                 s3_meta_reg;
    level_vec_t            s1_level_reg;
    level_vec_t            s_level;
    index_t                s_index;
    logic                  done_reg, done_next;
    logic [OUTQ_CNT_W-1:0] inflight_reg, inflight_next;
    logic                  accept;
    logic                  pop;
    logic                  fwd_hit;
    avg_vec_t              fast_rd, slow_rd;
    avg_vec_t              fast_new, slow_new;
    boost_vec_t            boost;

    assign s_level  = s_tdata[LANES*LEVEL_W-1:0];
    assign s_index  = s_tdata[LANES*LEVEL_W +: INDEX_W];
    assign s_tready = (inflight_reg < OUTQ_CNT_W'(OUTQ_DEPTH));
    assign accept   = s_tvalid & s_tready;
    assign pop      = m_tvalid & m_tready;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                CFG_FAST_COEF: cfg_next.fast_coef = cfg_wdata[COEF_W-1:0];
                CFG_SLOW_COEF: cfg_next.slow_coef = cfg_wdata[COEF_W-1:0];
                CFG_GAIN:      cfg_next.gain      = cfg_wdata[GAIN_W-1:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        s1_meta_next.valid = accept;
        s1_meta_next.first = 1'b0;
        s1_meta_next.index = s_index;
        s1_meta_next.last  = s_tlast;

        s2_meta_next       = s1_meta_reg;
        s2_meta_next.first = ~done_reg;

        done_next     = done_reg | (s1_meta_reg.valid & s1_meta_reg.last);
        inflight_next = inflight_reg + OUTQ_CNT_W'(accept) - OUTQ_CNT_W'(pop);
    end

    assign fwd_hit = s2_meta_reg.valid
                   && (s2_meta_reg.index[ADDR_W-1:0] == s1_meta_reg.index[ADDR_W-1:0]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.fast_coef <= FAST_COEF_RESET;
            cfg_reg.slow_coef <= SLOW_COEF_RESET;
            cfg_reg.gain      <= GAIN_RESET;
            s1_meta_reg       <= '0;
            s2_meta_reg       <= '0;
            s3_meta_reg       <= '0;
            done_reg          <= 1'b0;
            inflight_reg      <= '0;
        end else begin
            cfg_reg      <= cfg_next;
            s1_meta_reg  <= s1_meta_next;
            s2_meta_reg  <= s2_meta_next;
            s3_meta_reg  <= s2_meta_reg;
            done_reg     <= done_next;
            inflight_reg <= inflight_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_level_reg <= s_level;
        end
    end

    tiba_ram #(
        .WIDTH (LANES * AVG_W),
        .DEPTH (PIXEL_COUNT)
    ) u_fast_ram (
        .aclk    (aclk),
        .wr_en   (s1_meta_reg.valid),
        .wr_addr (s1_meta_reg.index[ADDR_W-1:0]),
        .wr_data (fast_new),
        .rd_en   (accept),
        .rd_addr (s_index[ADDR_W-1:0]),
        .rd_data (fast_rd)
    );

    tiba_ram #(
        .WIDTH (LANES * AVG_W),
        .DEPTH (PIXEL_COUNT)
    ) u_slow_ram (
        .aclk    (aclk),
        .wr_en   (s1_meta_reg.valid),
        .wr_addr (s1_meta_reg.index[ADDR_W-1:0]),
        .wr_data (slow_new),
        .rd_en   (accept),
        .rd_addr (s_index[ADDR_W-1:0]),
        .rd_data (slow_rd)
    );

    for (genvar g = 0; g < LANES; g++) begin : g_lane
        tiba_lane u_lane (
            .aclk     (aclk),
            .cfg      (cfg_reg),
            .level    (s1_level_reg[g]),
            .first    (~done_reg),
            .fwd_hit  (fwd_hit),
            .fast_rd  (fast_rd[g]),
            .slow_rd  (slow_rd[g]),
            .fast_new (fast_new[g]),
            .slow_new (slow_new[g]),
            .boost    (boost[g])
        );
    end

    tiba_outq u_outq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .meta     (s3_meta_reg),
        .boost    (boost),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

FILE: hw/rtl/tiba_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tiba_checker
// Port-level checks of the bandpass amplifier, bound to the top level.
// ----------------------------------------------------------------------------
module tiba_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [tiba_pkg::M_TDATA_W-1:0]   m_tdata,
    input logic                             m_tlast
);

    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed or dropped");

    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |-> ##4 m_tvalid)
        else $error("no result four cycles after an input transfer");

    a_empty_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input held off while output queue is empty");

endmodule

bind temporal_iir_bandpass_amplifier tiba_checker u_checker (.*);

FILE: sim/tb_temporal_iir_bandpass_amplifier.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_temporal_iir_bandpass_amplifier
// Self-checking bench for the temporal IIR bandpass amplifier.
// ----------------------------------------------------------------------------
// A first frame loads a fixed set of pixel slots, then frames scanning those
// slots run under several coefficient and gain settings, including the
// extremes. Pixels are streamed in with random gaps and results drained with
// random backpressure. Every result is checked against a bit-exact model of
// the fast and slow averages, rounding and saturation kept in the bench.
// ----------------------------------------------------------------------------
module tb_temporal_iir_bandpass_amplifier;
    import tiba_pkg::*;

    localparam int                     SLOT_COUNT    = 16;
    localparam int                     PHASE_ITEMS   = 120;
    localparam int                     DRAIN_CYCLES  = 8;
    localparam int                     CYCLE_LIMIT   = 400000;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE     = 2'd3;
    localparam logic [LEVEL_W-1:0]     LEVEL_MAX     = 16'hFFFF;
    localparam logic [CFG_DATA_W-1:0]  COEF_MAX      = 16'hFFFF;
    localparam logic [CFG_DATA_W-1:0]  GAIN_MAX      = 16'd1023;
    localparam longint                 BOOST_HI      = 64'sd8388607;
    localparam longint                 BOOST_LO      = -64'sd8388608;

    class boost_scoreboard;
        typedef struct packed {
            boost_vec_t boost;
            index_t     position;
            logic       last;
        } boost_item_t;

        avg_t              fast_avg [PIXEL_COUNT][LANES];
        avg_t              slow_avg [PIXEL_COUNT][LANES];
        bit                frame_seen;
        logic [COEF_W-1:0] fast_coef;
        logic [COEF_W-1:0] slow_coef;
        logic [GAIN_W-1:0] gain;
        boost_item_t       pending_boosts [$];
        int unsigned       mismatches;
        int unsigned       result_count;

        function new();
            frame_seen   = 0;
            fast_coef    = FAST_COEF_RESET;
            slow_coef    = SLOW_COEF_RESET;
            gain         = GAIN_RESET;
            mismatches   = 0;
            result_count = 0;
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                CFG_FAST_COEF: fast_coef = value[COEF_W-1:0];
                CFG_SLOW_COEF: slow_coef = value[COEF_W-1:0];
                CFG_GAIN:      gain      = value[GAIN_W-1:0];
                default: ;
            endcase
        endfunction

        function avg_t blend(avg_t avg, avg_t x, logic [COEF_W-1:0] c);
            logic [63:0] acc;
            acc = 64'(avg) * (64'd65536 - 64'(c)) + 64'(x) * 64'(c) + 64'd32768;
            return acc[AVG_W+15:16];
        endfunction

        function boost_t amplify(avg_t f, avg_t s, logic [GAIN_W-1:0] g);
            longint d;
            longint q;
            d = longint'(64'(f)) - longint'(64'(s));
            q = (d * longint'(64'(g)) + 128) >>> 8;
            if (q > BOOST_HI) q = BOOST_HI;
            if (q < BOOST_LO) q = BOOST_LO;
            return boost_t'(q[BOOST_W-1:0]);
        endfunction

        function void take_pixel(level_vec_t levels, index_t idx, logic last);
            boost_item_t e;
            avg_t        x;
            int          slot;
            slot = int'(idx) % PIXEL_COUNT;
            for (int l = 0; l < LANES; l++) begin
                x = {levels[l], 8'h00};
                if (!frame_seen) begin
                    fast_avg[slot][l] = x;
                    slow_avg[slot][l] = x;
                    e.boost[l] = '0;
                end else begin
                    fast_avg[slot][l] = blend(fast_avg[slot][l], x, fast_coef);
                    slow_avg[slot][l] = blend(slow_avg[slot][l], x, slow_coef);
                    e.boost[l] = amplify(fast_avg[slot][l], slow_avg[slot][l], gain);
                end
            end
            e.position = idx;
            e.last     = last;
            pending_boosts = {pending_boosts, e};
            if (last) frame_seen = 1;
        endfunction

        function void check_boost(logic [M_TDATA_W-1:0] data, logic last);
            boost_item_t got;
            boost_item_t want;
            got.boost    = data[LANES*BOOST_W-1:0];
            got.position = data[LANES*BOOST_W +: INDEX_W];
            got.last     = last;
            result_count++;
            if (pending_boosts.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result %0d with nothing pending: pos %0d", result_count,
                             got.position);
                return;
            end
            want = pending_boosts.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result %0d mismatch: expected r %0d g %0d b %0d pos %0d last %0b,",
                             result_count, $signed(want.boost[0]), $signed(want.boost[1]),
                             $signed(want.boost[2]), want.position, want.last,
                             " got r %0d g %0d b %0d pos %0d last %0b",
                             $signed(got.boost[0]), $signed(got.boost[1]),
                             $signed(got.boost[2]), got.position, got.last);
            end
        endfunction

        function int pending_count();
            return pending_boosts.size();
        endfunction
    endclass

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata;   // red, green, blue level, index
    logic                   s_tlast;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_TDATA_W-1:0]   m_tdata;   // red, green, blue boost, position
    logic                   m_tlast;
    logic                   cfg_wr_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wdata;

    boost_scoreboard boosts;
    bit              steady;
    int unsigned     cycle_count;
    index_t          slots [$];

    temporal_iir_bandpass_amplifier dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #1 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            boosts.check_boost(m_tdata, m_tlast);
        end
    end

    // stall the result side for a random number of cycles per transfer
    initial begin
        int stall;
        m_tready = 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            stall = steady ? 0 : $urandom_range(0, 10);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && m_tready));
        end
    end

    task automatic send_pixel(level_vec_t levels, index_t idx, logic last);
        int                   gap;
        logic [S_TDATA_W-1:0] word;
        gap = steady ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        word = '0;
        word[LANES*LEVEL_W-1:0]        = levels;
        word[LANES*LEVEL_W +: INDEX_W] = idx;
        s_tdata  <= word;
        s_tlast  <= last;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        boosts.take_pixel(levels, idx, last);
    endtask

    // hold the sender off until every result is back, then let the pipe settle
    task automatic drain();
        s_tvalid <= 1'b0;
        while (boosts.pending_count() > 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        boosts.write_reg(idx, value);
    endtask

    task automatic program_regs(logic [CFG_DATA_W-1:0] fast, logic [CFG_DATA_W-1:0] slow,
                                logic [CFG_DATA_W-1:0] amp);
        write_reg(CFG_FAST_COEF, fast);
        write_reg(CFG_SLOW_COEF, slow);
        write_reg(CFG_GAIN, amp);
        write_reg(CFG_SPARE, 16'($urandom));
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic level_t draw_level();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return LEVEL_MAX;
            default: return level_t'($urandom);
        endcase
    endfunction

    function automatic level_vec_t draw_levels();
        level_vec_t v;
        for (int l = 0; l < LANES; l++) v[l] = draw_level();
        return v;
    endfunction

    // scan the loaded slots as frames, with repeats, jumps and stray frame ends
    task automatic run_frames(int count);
        int     pos;
        int     pick;
        index_t idx;
        logic   last;
        pos = 0;
        idx = slots[0];
        for (int n = 0; n < count; n++) begin
            if (n % 40 == 0) steady = ($urandom_range(0, 2) == 0);
            pick = $urandom_range(0, 9);
            if (pick < 2 && n > 0) begin
                last = ($urandom_range(0, 19) == 0);
            end else if (pick == 2) begin
                idx  = slots[$urandom_range(0, SLOT_COUNT - 1)];
                last = ($urandom_range(0, 19) == 0);
            end else begin
                idx  = slots[pos];
                pos  = (pos + 1) % SLOT_COUNT;
                last = (pos == 0) || ($urandom_range(0, 19) == 0);
            end
            send_pixel(draw_levels(), idx, last);
        end
    endtask

    initial begin
        bit               used [PIXEL_COUNT];
        index_t           r;
        logic [CFG_DATA_W-1:0] fast;
        logic [CFG_DATA_W-1:0] slow;
        logic [CFG_DATA_W-1:0] amp;

        aclk        = 1'b0;
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tlast     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_index   = CFG_FAST_COEF;
        cfg_wdata   = '0;
        cycle_count = 0;
        steady      = 1'b0;
        boosts      = new();

        foreach (used[i]) used[i] = 0;
        slots = {slots, index_t'(0)};
        slots = {slots, index_t'(PIXEL_COUNT - 1)};
        slots = {slots, index_t'(PIXEL_COUNT / 2)};
        slots = {slots, index_t'(PIXEL_COUNT / 2 - 1)};
        foreach (slots[i]) used[slots[i]] = 1;
        while (slots.size() < SLOT_COUNT) begin
            r = index_t'($urandom_range(0, PIXEL_COUNT - 1));
            if (!used[r]) begin
                used[r] = 1;
                slots = {slots, r};
            end
        end

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // first frame: load every slot, reload one, end of frame on the last slot
        send_pixel('0, slots[0], 1'b0);
        send_pixel({LEVEL_MAX, LEVEL_MAX, LEVEL_MAX}, slots[1], 1'b0);
        send_pixel(draw_levels(), slots[0], 1'b0);
        for (int i = 2; i < SLOT_COUNT; i++) begin
            send_pixel(draw_levels(), slots[i], i == SLOT_COUNT - 1);
        end

        // reset coefficients: full swing both ways, a back-to-back repeat, mixed lanes
        send_pixel({LEVEL_MAX, LEVEL_MAX, LEVEL_MAX}, slots[0], 1'b0);
        send_pixel({LEVEL_MAX, LEVEL_MAX, LEVEL_MAX}, slots[0], 1'b0);
        send_pixel('0, slots[1], 1'b0);
        send_pixel({16'h8000, LEVEL_MAX, 16'h0000}, slots[2], 1'b1);
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: begin fast = COEF_MAX; slow = '0;       amp = GAIN_MAX; end
                1: begin fast = '0;       slow = COEF_MAX; amp = GAIN_MAX; end
                2: begin fast = '0;       slow = '0;       amp = '0;       end
                3: begin fast = COEF_MAX; slow = COEF_MAX; amp = 16'd1;    end
                default: begin
                    fast = 16'($urandom);
                    slow = 16'($urandom);
                    amp  = 16'($urandom);
                end
            endcase
            program_regs(fast, slow, amp);
            run_frames(PHASE_ITEMS);
            drain();
        end

        if (boosts.mismatches == 0 && boosts.pending_count() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/tiba_pkg.sv
hw/rtl/tiba_ram.sv
hw/rtl/tiba_lane.sv
hw/rtl/tiba_outq.sv
hw/rtl/temporal_iir_bandpass_amplifier.sv
hw/rtl/tiba_checker.sv
sim/tb_temporal_iir_bandpass_amplifier.sv
